// File: rtl/fpfa_pkg.sv
`timescale 1ns / 1ps

package fpfa_pkg;

	// Default build of the partition table
	localparam int PARTITIONS_DEF = 128;
	localparam int SIZE_BITS_DEF  = 16;

	// Fixed widths of the transaction fields
	localparam int STRAT_W  = 2;
	localparam int PIDX_W   = 7;
	localparam int SIZE_W   = 16;
	localparam int STATUS_W = 2;

	typedef logic [STRAT_W-1:0]  strategy_t;
	typedef logic [STATUS_W-1:0] status_t;

	// Request kinds
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_ALLOC = 1'b1;

	// Allocation rules; the remaining code fits nothing
	localparam strategy_t STRAT_FIRST = 2'd0;
	localparam strategy_t STRAT_BEST  = 2'd1;
	localparam strategy_t STRAT_WORST = 2'd2;

	// Result codes
	localparam status_t STAT_LOADED  = 2'd0;
	localparam status_t STAT_GRANTED = 2'd1;
	localparam status_t STAT_NOFIT   = 2'd2;

	// Sequencer to scanner control
	typedef struct packed {
		logic      clear;
		logic      sample;
		strategy_t strategy;
	} scan_ctl_t;

endpackage

// File: rtl/fpfa_if.sv
`timescale 1ns / 1ps

interface fpfa_req_if;
	import fpfa_pkg::*;

	logic              valid;
	logic              ready;
	logic              req_type;
	strategy_t         strategy;
	logic [PIDX_W-1:0] partition_index;
	logic [SIZE_W-1:0] new_size;
	logic [SIZE_W-1:0] request_size;

	modport source (
		output valid, req_type, strategy, partition_index, new_size, request_size,
		input  ready
	);
	modport sink (
		input  valid, req_type, strategy, partition_index, new_size, request_size,
		output ready
	);
endinterface

interface fpfa_rsp_if;
	import fpfa_pkg::*;

	logic              valid;
	logic              ready;
	status_t           status;
	logic [PIDX_W-1:0] block_index;

	modport source (
		output valid, status, block_index,
		input  ready
	);
	modport sink (
		input  valid, status, block_index,
		output ready
	);
endinterface

// File: rtl/fpfa_store.sv
`timescale 1ns / 1ps

module fpfa_store #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 17,
	parameter int AW    = 7
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/fpfa_scan.sv
`timescale 1ns / 1ps

module fpfa_scan #(
	parameter int IDX_W     = 7,
	parameter int SIZE_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fpfa_pkg::scan_ctl_t         ctl,
	input  logic [fpfa_pkg::SIZE_W-1:0] need,
	input  logic [IDX_W-1:0]            addr,
	input  logic                        taken,
	input  logic [SIZE_BITS-1:0]        size,
	output logic                        found,
	output logic [IDX_W-1:0]            best_idx,
	output logic [SIZE_BITS-1:0]        best_size
);
	import fpfa_pkg::*;

	localparam int CMP_W = (SIZE_BITS > SIZE_W) ? SIZE_BITS : SIZE_W;

	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [SIZE_BITS-1:0] best_size_q;
	logic                 fit;
	logic                 better;
	logic                 take;

	// Entry is free and large enough
	assign fit = !taken && (CMP_W'(size) >= CMP_W'(need));

	// Strict improvement keeps ties on the lowest index
	always_comb begin
		unique case (ctl.strategy)
			STRAT_BEST:  better = size < best_size_q;
			STRAT_WORST: better = size > best_size_q;
			default:     better = 1'b0;
		endcase
	end

	assign take = ctl.sample && fit && (!found_q || better);

	// Track the chosen entry over the sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q  <= addr;
			best_size_q <= size;
		end
	end

	assign found     = found_q;
	assign best_idx  = best_idx_q;
	assign best_size = best_size_q;

`ifndef SYNTHESIS
	a_found_drops_on_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(found_q) |-> $past(ctl.clear))
		else $error("scan result lost without a clear");
	a_found_needs_free: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(found_q) |-> $past(ctl.sample && !taken))
		else $error("scan picked a taken or unsampled entry");
	a_taken_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.sample && taken && !found_q) |=> !found_q)
		else $error("taken entry raised the scan result");
`endif

endmodule

// File: rtl/fixed_partition_fit_allocator_unit.sv
`timescale 1ns / 1ps

// Fixed-partition allocator: a table of PARTITIONS entries, each a size of SIZE_BITS and a taken
// mark, held in one single-port-read, single-port-write memory. After reset a clearing pass
// writes every entry to zero, during which no request transaction is taken. A load
// transaction writes its entry on acceptance if its index lies in the table, and its result
// then passes through the hand-off state into the output register; an allocate transaction
// with an undefined rule takes the same path and answers "no fit". A first, best or worst fit
// allocation sweeps the whole table one entry per cycle through the memory read port, then
// passes through the drain state and the commit state, which writes the taken mark, to the
// hand-off state. One transaction is in work at a time; a finished result waits in the output
// register while the next request is accepted.
module fixed_partition_fit_allocator_unit #(
	parameter int PARTITIONS = fpfa_pkg::PARTITIONS_DEF,
	parameter int SIZE_BITS  = fpfa_pkg::SIZE_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	fpfa_req_if.sink   req,
	fpfa_rsp_if.source rsp
);
	import fpfa_pkg::*;

	localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
	localparam int ENT_W = SIZE_BITS + 1;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(PARTITIONS - 1);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_COMMIT = 3'd4;
	localparam logic [2:0] ST_WAIT   = 3'd5;

	logic [2:0]        state_q;
	logic [IDX_W-1:0]  cnt_q;
	strategy_t         strategy_q;
	logic [SIZE_W-1:0] need_q;
	logic              rd_valid_s1;
	logic [IDX_W-1:0]  rd_addr_s1;
	status_t           pend_status_q;
	logic [PIDX_W-1:0] pend_index_q;
	logic              out_valid_q;
	status_t           out_status_q;
	logic [PIDX_W-1:0] out_index_q;

	logic              acc;
	logic              slot_free;
	logic              load_in_range;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [ENT_W-1:0]  mem_wdata;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr;
	logic [ENT_W-1:0]  mem_rdata;

	scan_ctl_t            scan_ctl;
	logic                 found;
	logic [IDX_W-1:0]     best_idx;
	logic [SIZE_BITS-1:0] best_size;

	assign req.ready     = (state_q == ST_IDLE);
	assign acc           = req.valid && req.ready;
	assign slot_free     = !out_valid_q || rsp.ready;
	assign load_in_range = 32'(req.partition_index) < PARTITIONS;

	// Drive the memory ports from the sequencer state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = cnt_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				if (acc && req.req_type == REQ_LOAD && load_in_range) begin
					mem_we    = 1'b1;
					mem_waddr = IDX_W'(req.partition_index);
					mem_wdata = {1'b0, SIZE_BITS'(req.new_size)};
				end
			end
			ST_SCAN: begin
				mem_re = 1'b1;
			end
			ST_COMMIT: begin
				if (found) begin
					mem_we    = 1'b1;
					mem_waddr = best_idx;
					mem_wdata = {1'b1, best_size};
				end
			end
			default: begin
			end
		endcase
	end

	fpfa_store #(
		.DEPTH (PARTITIONS),
		.WIDTH (ENT_W),
		.AW    (IDX_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Feed each returned entry to the scanner
	assign scan_ctl.clear    = acc && req.req_type == REQ_ALLOC;
	assign scan_ctl.sample   = rd_valid_s1;
	assign scan_ctl.strategy = strategy_q;

	fpfa_scan #(
		.IDX_W     (IDX_W),
		.SIZE_BITS (SIZE_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.need      (need_q),
		.addr      (rd_addr_s1),
		.taken     (mem_rdata[ENT_W-1]),
		.size      (mem_rdata[SIZE_BITS-1:0]),
		.found     (found),
		.best_idx  (best_idx),
		.best_size (best_size)
	);

	// Sequence clear, scan, commit and result hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= mem_re;
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						if (req.req_type == REQ_LOAD || req.strategy > STRAT_WORST) begin
							state_q <= ST_WAIT;
						end else begin
							cnt_q   <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						cnt_q   <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (state_q == ST_WAIT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold request fields, pending result and output payload
	always_ff @(posedge clk) begin
		rd_addr_s1 <= mem_raddr;
		if (acc) begin
			strategy_q <= req.strategy;
			need_q     <= req.request_size;
			if (req.req_type == REQ_LOAD) begin
				pend_status_q <= STAT_LOADED;
				pend_index_q  <= req.partition_index;
			end else begin
				pend_status_q <= STAT_NOFIT;
				pend_index_q  <= '0;
			end
		end
		if (state_q == ST_COMMIT && found) begin
			pend_status_q <= STAT_GRANTED;
			pend_index_q  <= PIDX_W'(best_idx);
		end
		if (state_q == ST_WAIT && slot_free) begin
			out_status_q <= pend_status_q;
			out_index_q  <= pend_index_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.block_index = out_index_q;

`ifndef SYNTHESIS
	a_out_from_wait: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_WAIT))
		else $error("result raised outside the hand-off state");
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (32'(cnt_q) < PARTITIONS))
		else $error("scan address beyond the table");
	a_commit_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT && found) |-> (mem_we && mem_waddr == best_idx))
		else $error("granted partition not marked taken");
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (state_q == ST_SCAN || state_q == ST_WAIT))
		else $error("accepted transaction not taken into work");
`endif

endmodule

// File: dv/fixed_partition_fit_allocator_checker.sv
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_checker #(
	parameter int PARTITIONS = fpfa_pkg::PARTITIONS_DEF,
	parameter int SIZE_BITS  = fpfa_pkg::SIZE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	fpfa_req_if  req,
	fpfa_rsp_if  rsp,
	output int   failures,
	output int   pending,
	output int   loads_seen,
	output int   grants_seen,
	output int   refusals_seen
);
	import fpfa_pkg::*;

	typedef struct packed {
		status_t           status;
		logic [PIDX_W-1:0] block_index;
	} fit_outcome_t;

	// Shadow copy of the partition table
	logic [SIZE_BITS-1:0] size_mirror  [PARTITIONS];
	logic                 taken_mirror [PARTITIONS];
	fit_outcome_t         outcome_queue [$];
	fit_outcome_t         oldest;

	// Update the shadow table for one request and return the answer it must produce
	function automatic fit_outcome_t apply_request(input logic kind, input strategy_t rule,
		input logic [PIDX_W-1:0] idx, input logic [SIZE_W-1:0] load_size,
		input logic [SIZE_W-1:0] need);
		fit_outcome_t    res;
		bit              found;
		int              chosen;
		int              i;
		longint unsigned chosen_size;
		longint unsigned cand;

		res.status      = STAT_NOFIT;
		res.block_index = '0;
		found           = 1'b0;
		chosen          = 0;
		chosen_size     = 0;

		// Load: write the entry if it exists and free it; answer with the index regardless
		if (kind == REQ_LOAD) begin
			if (int'(idx) < PARTITIONS) begin
				size_mirror[idx]  = SIZE_BITS'(load_size);
				taken_mirror[idx] = 1'b0;
			end
			res.status      = STAT_LOADED;
			res.block_index = idx;
			return res;
		end

		// Unknown rule fits nothing
		if (rule != STRAT_FIRST && rule != STRAT_BEST && rule != STRAT_WORST)
			return res;

		// Sweep the table; ties stay with the lowest index
		for (i = 0; i < PARTITIONS && !(found && rule == STRAT_FIRST); i++) begin
			cand = size_mirror[i];
			if (!taken_mirror[i] && cand >= need) begin
				if (!found) begin
					found       = 1'b1;
					chosen      = i;
					chosen_size = cand;
				end else if ((rule == STRAT_BEST && cand < chosen_size) ||
					     (rule == STRAT_WORST && cand > chosen_size)) begin
					chosen      = i;
					chosen_size = cand;
				end
			end
		end

		if (found) begin
			taken_mirror[chosen] = 1'b1;
			res.status           = STAT_GRANTED;
			res.block_index      = PIDX_W'(chosen);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// Clear the shadow table and drop anything outstanding
			for (int j = 0; j < PARTITIONS; j++) begin
				size_mirror[j]  = '0;
				taken_mirror[j] = 1'b0;
			end
			outcome_queue.delete();
			failures      = 0;
			pending       = 0;
			loads_seen    = 0;
			grants_seen   = 0;
			refusals_seen = 0;
		end else begin
			// Check a delivered result against the oldest prediction
			if (rsp.valid && rsp.ready) begin
				if (outcome_queue.size() == 0) begin
					$display("%0t: unexpected result, status %0d index %0d", $realtime,
						rsp.status, rsp.block_index);
					failures++;
				end else begin
					oldest = outcome_queue.pop_front();
					if (rsp.status !== oldest.status) begin
						$display("%0t: status mismatch, expected %0d, got %0d", $realtime,
							oldest.status, rsp.status);
						failures++;
					end
					if (rsp.block_index !== oldest.block_index) begin
						$display("%0t: block_index mismatch, expected %0d, got %0d",
							$realtime, oldest.block_index, rsp.block_index);
						failures++;
					end
					case (oldest.status)
						STAT_LOADED:  loads_seen++;
						STAT_GRANTED: grants_seen++;
						default:      refusals_seen++;
					endcase
				end
			end

			// Predict the answer for each accepted request transaction
			if (req.valid && req.ready)
				outcome_queue.push_back(apply_request(req.req_type, req.strategy,
					req.partition_index, req.new_size, req.request_size));

			pending = outcome_queue.size();
		end
	end

endmodule

// File: dv/fixed_partition_fit_allocator_unit_tb.sv
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_unit_tb;
	import fpfa_pkg::*;

	localparam int PARTITIONS       = PARTITIONS_DEF;
	localparam int SIZE_BITS        = SIZE_BITS_DEF;
	localparam int RANDOM_PER_PHASE = 440;
	localparam int SETTLE_CYCLES    = 2 * PARTITIONS + 16;
	localparam int CYCLE_LIMIT      = 2_000_000;

	// The package leaves the fourth rule code unnamed
	localparam strategy_t STRAT_UNDEF = 2'd3;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int failures;
	int pending_results;
	int loads_seen;
	int grants_seen;
	int refusals_seen;
	int cycle_count = 0;
	int sender_idle_pct = 0;
	int sink_stall_pct  = 0;

	fpfa_req_if req_if ();
	fpfa_rsp_if rsp_if ();

	fixed_partition_fit_allocator_unit #(
		.PARTITIONS(PARTITIONS),
		.SIZE_BITS (SIZE_BITS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	fixed_partition_fit_allocator_checker #(
		.PARTITIONS(PARTITIONS),
		.SIZE_BITS (SIZE_BITS)
	) fit_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_if),
		.rsp          (rsp_if),
		.failures     (failures),
		.pending      (pending_results),
		.loads_seen   (loads_seen),
		.grants_seen  (grants_seen),
		.refusals_seen(refusals_seen)
	);

	always #2 clk = ~clk;

	// Stall the result side at the current phase rate
	always @(negedge clk) begin
		rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	// Present one request and hold it until the block takes it
	task automatic send_request(input logic kind, input strategy_t rule,
		input logic [PIDX_W-1:0] idx, input logic [SIZE_W-1:0] load_size,
		input logic [SIZE_W-1:0] need);
		@(negedge clk);
		req_if.valid           <= 1'b1;
		req_if.req_type        <= kind;
		req_if.strategy        <= rule;
		req_if.partition_index <= idx;
		req_if.new_size        <= load_size;
		req_if.request_size    <= need;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
	endtask

	// Hold off until every outstanding result has been delivered
	task automatic drain_results();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
	endtask

	initial begin
		int                phase;
		int                n;
		int unsigned       roll;
		logic [PIDX_W-1:0] idx;
		logic [SIZE_W-1:0] size_val;
		logic [SIZE_W-1:0] need;
		strategy_t         rule;
		int                idle_by_phase  [4];
		int                stall_by_phase [4];

		idle_by_phase  = '{0, 78, 0, 37};
		stall_by_phase = '{0, 0, 78, 37};

		req_if.valid           = 1'b0;
		req_if.req_type        = REQ_LOAD;
		req_if.strategy        = STRAT_FIRST;
		req_if.partition_index = '0;
		req_if.new_size        = '0;
		req_if.request_size    = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, ties, every rule, the unknown rule and zero requests
		send_request(REQ_LOAD,  STRAT_FIRST, 7'd0,   16'hFFFF, 16'h0000);
		send_request(REQ_LOAD,  STRAT_FIRST, 7'd127, 16'h0000, 16'h0000);
		send_request(REQ_LOAD,  STRAT_FIRST, 7'd5,   16'd10,   16'h0000);
		send_request(REQ_LOAD,  STRAT_FIRST, 7'd6,   16'd10,   16'h0000);
		send_request(REQ_LOAD,  STRAT_FIRST, 7'd9,   16'd10,   16'h0000);
		send_request(REQ_LOAD,  STRAT_FIRST, 7'd7,   16'd20,   16'h0000);
		send_request(REQ_LOAD,  STRAT_FIRST, 7'd8,   16'hFFFE, 16'h0000);
		send_request(REQ_ALLOC, STRAT_FIRST, 7'd0,   16'h0000, 16'hFFFF);
		send_request(REQ_ALLOC, STRAT_FIRST, 7'd0,   16'h0000, 16'hFFFF);
		send_request(REQ_ALLOC, STRAT_BEST,  7'd0,   16'h0000, 16'd10);
		send_request(REQ_ALLOC, STRAT_BEST,  7'd0,   16'h0000, 16'd11);
		send_request(REQ_ALLOC, STRAT_WORST, 7'd0,   16'h0000, 16'd10);
		send_request(REQ_ALLOC, STRAT_WORST, 7'd0,   16'h0000, 16'd10);
		send_request(REQ_ALLOC, STRAT_UNDEF, 7'd0,   16'h0000, 16'h0000);
		send_request(REQ_ALLOC, STRAT_FIRST, 7'd0,   16'h0000, 16'h0000);
		send_request(REQ_ALLOC, STRAT_BEST,  7'd0,   16'h0000, 16'h0000);
		send_request(REQ_ALLOC, STRAT_WORST, 7'd0,   16'h0000, 16'h0000);
		send_request(REQ_LOAD,  STRAT_UNDEF, 7'd0,   16'h5555, 16'hAAAA);
		send_request(REQ_ALLOC, STRAT_WORST, 7'd0,   16'h0000, 16'd1);
		send_request(REQ_LOAD,  STRAT_FIRST, 7'd3,   16'hAAAA, 16'h5555);
		send_request(REQ_ALLOC, STRAT_BEST,  7'h7F,  16'hFFFF, 16'hAAAA);
		send_request(REQ_ALLOC, STRAT_WORST, 7'd0,   16'h0000, 16'hFFFF);
		send_request(REQ_LOAD,  STRAT_FIRST, 7'd127, 16'hFFFF, 16'h0000);
		send_request(REQ_ALLOC, STRAT_FIRST, 7'd0,   16'h0000, 16'hFFFF);
		drain_results();

		// Random phases under different handshake pressure
		for (phase = 0; phase < 4; phase++) begin
			sender_idle_pct = idle_by_phase[phase];
			sink_stall_pct  = stall_by_phase[phase];
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				while ($urandom_range(99) < sender_idle_pct) begin
					@(negedge clk);
					req_if.valid <= 1'b0;
				end

				// Loads mostly land in a small hot window so that allocations collide
				idx = ($urandom_range(4) == 0) ? PIDX_W'($urandom) : PIDX_W'($urandom_range(15));
				roll = $urandom_range(9);
				if (roll < 5)
					size_val = SIZE_W'($urandom_range(32));
				else if (roll < 7)
					size_val = SIZE_W'($urandom_range(1100, 1000));
				else if (roll == 7)
					size_val = '0;
				else if (roll == 8)
					size_val = '1;
				else
					size_val = SIZE_W'($urandom);

				// Requests aim at the same size bands as the loads
				roll = $urandom_range(9);
				if (roll < 4)
					need = SIZE_W'($urandom_range(32));
				else if (roll < 6)
					need = SIZE_W'($urandom_range(1100, 1000));
				else if (roll == 6)
					need = '0;
				else if (roll == 7)
					need = '1;
				else
					need = SIZE_W'($urandom);

				roll = $urandom_range(9);
				if (roll < 3)
					rule = STRAT_FIRST;
				else if (roll < 6)
					rule = STRAT_BEST;
				else if (roll < 9)
					rule = STRAT_WORST;
				else
					rule = STRAT_UNDEF;

				if ($urandom_range(99) < 45)
					send_request(REQ_LOAD, strategy_t'($urandom_range(3)), idx, size_val, need);
				else
					send_request(REQ_ALLOC, rule, idx, size_val, need);
			end
			drain_results();
		end

		// Let any stray result surface before the verdict
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Covered %0d loads, %0d grants and %0d no-fit answers", loads_seen,
			grants_seen, refusals_seen);
		$display("under free-running, sender-idle, receiver-stall and mixed handshake phases");
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
